// ===== design/bsr_pkg.sv =====
// Shared types and constants for the bounded stack with indexed removal.
`default_nettype none

package bsr_pkg;

  // Default sizing handed to the top level's parameters
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int ENTRY_BITS_DEF  = 8;

  // Fixed field widths of the request and result channels
  localparam int ACTION_W     = 3;
  localparam int ENTRY_PORT_W = 8;
  localparam int SLOT_W       = 6;
  localparam int TAKE_W       = 7;
  localparam int VIEW_W       = 6;
  localparam int LEVEL_W      = 7;
  localparam int VIS_W        = 7;

  // Most entries one remove-top-n request may pop, and the widest window
  localparam int RESULT_CAP = 64;
  localparam int WINDOW_MAX = 64;

  // Register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD        = 3'd0,
    ACT_GET        = 3'd1,
    ACT_REMOVE_AT  = 3'd2,
    ACT_REMOVE_TOP = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_POSITION   = 3'd5
  } bsr_action_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } bsr_state_t;

  typedef enum logic [1:0] {
    REG_VISIBLE = 2'd0,
    REG_FOLLOW  = 2'd1,
    REG_SPREAD  = 2'd2
  } bsr_reg_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    logic load_en;   // write din into the cell addressed by wr_ptr
    logic shift_en;  // cells at or above rm_ptr take their upper neighbour
  } bsr_cell_ctl_t;

endpackage

`default_nettype wire

// ===== design/bsr_cell.sv =====
// One storage cell of the stack row: load, shift-down from neighbour, read tap.
`default_nettype none

module bsr_cell #(
  parameter int IDX_W      = 6,
  parameter int CELL_IDX   = 0,
  parameter int ENTRY_BITS = 8
) (
  input  logic                   clk,
  input  bsr_pkg::bsr_cell_ctl_t ctl,
  input  logic [IDX_W-1:0]       wr_ptr,
  input  logic [IDX_W-1:0]       rm_ptr,
  input  logic [IDX_W-1:0]       rd_ptr,
  input  logic [ENTRY_BITS-1:0]  din,
  input  logic [ENTRY_BITS-1:0]  nbr,
  output logic [ENTRY_BITS-1:0]  q,
  output logic [ENTRY_BITS-1:0]  rd_part
);
  import bsr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [ENTRY_BITS-1:0] data_r;
  logic [ENTRY_BITS-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load_en && (wr_ptr == MY_IDX)) begin
      data_nxt = din;
    end else if (ctl.shift_en && (MY_IDX >= rm_ptr)) begin
      data_nxt = nbr;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q       = data_r;
  // zero unless addressed, so the row ORs into one read bus
  assign rd_part = (rd_ptr == MY_IDX) ? data_r : '0;

endmodule

`default_nettype wire

// ===== design/bounded_stack_with_indexed_removal.sv =====
// Top level: bounded stack of entries held in a row of cells, with indexed removal.
//
// Requests enter on the in_ valid/ready channel; each one carries an action
// (add, get, remove at, remove top n, clear, position). Results leave on the
// out_ valid/ready channel, every request giving one or more results, the
// final one flagged by out_last. Window registers sit behind an APB-style
// port (pready tied high) and are to be written only while the block is idle;
// the block itself does not enforce this. A result appears in the output
// register the cycle after its request is taken. Throughput: one request per
// cycle while the result side keeps up, for every action except a remove top
// n that pops more than one entry, which holds in_ready low and hands out one
// popped entry per cycle while results are taken. The rate is set by the single
// read bus across the row of cells, which serves one entry per cycle.
// A stalled receiver holds the output register; a new request is still
// taken while the slot frees in the same cycle, otherwise in_ready drops.
// Reset (synchronous, rst_n low) empties the stack, zeroes the scroll
// offset and restores the window registers; cell contents are left as they
// are and never read before being written, so no clearing pass is needed.
`default_nettype none

module bounded_stack_with_indexed_removal #(
  parameter int MAX_ENTRIES = bsr_pkg::MAX_ENTRIES_DEF,
  parameter int ENTRY_BITS  = bsr_pkg::ENTRY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bsr_pkg::PADDR_W-1:0]       paddr,
  input  logic [bsr_pkg::PDATA_W-1:0]       pwdata,
  output logic [bsr_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bsr_pkg::ACTION_W-1:0]      in_action,
  input  logic [bsr_pkg::ENTRY_PORT_W-1:0]  in_entry_in,
  input  logic [bsr_pkg::SLOT_W-1:0]        in_slot_index,
  input  logic [bsr_pkg::TAKE_W-1:0]        in_take_count,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bsr_pkg::ENTRY_PORT_W-1:0]  out_entry_out,
  output logic                              out_found,
  output logic                              out_last,
  output logic [bsr_pkg::VIEW_W-1:0]        out_view_slot,
  output logic [bsr_pkg::LEVEL_W-1:0]       out_fill_level,
  output logic [bsr_pkg::LEVEL_W-1:0]       out_scroll_now
);
  import bsr_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  // common width for index / count / window arithmetic
  localparam int CW    = (CNT_W > TAKE_W) ? CNT_W : TAKE_W;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  bsr_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]          scroll_r, scroll_nxt;
  logic [CNT_W-1:0]       pop_ptr_r, pop_ptr_nxt;   // next entry to hand out
  logic [CNT_W-1:0]       pop_end_r, pop_end_nxt;   // fill before the pop
  logic [VIS_W-1:0]       vis_r, vis_nxt;
  logic                   follow_r, follow_nxt;
  logic                   spread_r, spread_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [ENTRY_PORT_W-1:0] out_entry_r;
  logic                   out_found_r;
  logic                   out_last_r;
  logic [VIEW_W-1:0]      out_view_r;
  logic [LEVEL_W-1:0]     out_fill_r;
  logic [LEVEL_W-1:0]     out_scroll_r;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  logic     cfg_wr;
  bsr_reg_t cfg_reg;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_reg = bsr_reg_t'(paddr[PADDR_W-1:2]);

  always_comb begin
    vis_nxt    = vis_r;
    follow_nxt = follow_r;
    spread_nxt = spread_r;
    if (cfg_wr) begin
      unique case (cfg_reg)
        REG_VISIBLE: vis_nxt    = pwdata[VIS_W-1:0];
        REG_FOLLOW:  follow_nxt = pwdata[0];
        REG_SPREAD:  spread_nxt = pwdata[0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_VISIBLE: prdata = PDATA_W'(vis_r);
      REG_FOLLOW:  prdata = PDATA_W'(follow_r);
      REG_SPREAD:  prdata = PDATA_W'(spread_r);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request decode and window arithmetic
  // ---------------------------------------------------------------------
  bsr_action_t      act;
  logic             out_free;
  logic             in_accept;
  logic [VIS_W-1:0] vis_eff;
  logic [CW-1:0]    fill_x, idx_x, take_x, vis_x;
  logic             hit;
  logic             full;
  logic [CW-1:0]    n_min, n_pop, fill_pop;
  logic [CW-1:0]    fill_after, scroll_follow;
  logic [CW:0]      win_end;
  logic [VIEW_W-1:0] pos_view;
  logic [CNT_W-1:0] pop_ptr_inc;
  logic             pop_last;

  assign act       = bsr_action_t'(in_action);
  // output slot is free when empty or emptying this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_accept = in_valid && in_ready;

  // window of zero acts as one, oversize clamps to the widest window
  always_comb begin
    if (vis_r == '0) begin
      vis_eff = VIS_W'(1);
    end else if (vis_r > VIS_W'(WINDOW_MAX)) begin
      vis_eff = VIS_W'(WINDOW_MAX);
    end else begin
      vis_eff = vis_r;
    end
  end

  assign fill_x = CW'(fill_r);
  assign idx_x  = CW'(in_slot_index);
  assign take_x = CW'(in_take_count);
  assign vis_x  = CW'(vis_eff);
  assign hit    = idx_x < fill_x;
  assign full   = fill_r == CNT_W'(MAX_ENTRIES);

  // entries popped: min(take, fill, cap)
  assign n_min    = (take_x < fill_x) ? take_x : fill_x;
  assign n_pop    = (n_min > CW'(RESULT_CAP)) ? CW'(RESULT_CAP) : n_min;
  assign fill_pop = fill_x - n_pop;

  // fill after a change, for the follow-top scroll
  always_comb begin
    case (act)
      ACT_ADD:        fill_after = fill_x + CW'(1);
      ACT_REMOVE_AT:  fill_after = fill_x - CW'(1);
      ACT_REMOVE_TOP: fill_after = fill_pop;
      default:        fill_after = fill_x;
    endcase
  end

  assign scroll_follow = !follow_r ? scroll_r :
                         (fill_after > vis_x) ? (fill_after - vis_x) : '0;

  // position: before the window -> slot 0, past it -> last slot or 0
  assign win_end = {1'b0, scroll_r} + {1'b0, vis_x};
  always_comb begin
    if (idx_x < scroll_r) begin
      pos_view = '0;
    end else if ({1'b0, idx_x} >= win_end) begin
      pos_view = spread_r ? VIEW_W'(vis_x - CW'(1)) : '0;
    end else begin
      pos_view = VIEW_W'(idx_x - scroll_r);
    end
  end

  assign pop_ptr_inc = pop_ptr_r + CNT_W'(1);
  assign pop_last    = pop_ptr_inc == pop_end_r;

  // ---------------------------------------------------------------------
  // Cell row and shared read bus
  // ---------------------------------------------------------------------
  bsr_cell_ctl_t         cell_ctl;
  logic [CW-1:0]         rd_addr;
  logic [IDX_W-1:0]      rd_ptr;
  logic [IDX_W-1:0]      wr_ptr;
  logic [IDX_W-1:0]      rm_ptr;
  logic [ENTRY_BITS-1:0] din;
  logic [ENTRY_BITS-1:0] cell_q  [MAX_ENTRIES];
  logic [ENTRY_BITS-1:0] cell_rd [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] rd_col [ENTRY_BITS];
  logic [ENTRY_BITS-1:0] rd_data;

  // read address: popped entries come from the pop pointer, else per action
  always_comb begin
    if (state_r == ST_POP) begin
      rd_addr = CW'(pop_ptr_r);
    end else begin
      case (act)
        ACT_GET:        rd_addr = fill_x - idx_x - CW'(1);
        ACT_REMOVE_AT:  rd_addr = idx_x;
        ACT_REMOVE_TOP: rd_addr = fill_pop;
        default:        rd_addr = '0;
      endcase
    end
  end

  assign rd_ptr = rd_addr[IDX_W-1:0];
  assign wr_ptr = IDX_W'(fill_r);
  assign rm_ptr = IDX_W'(idx_x);
  assign din    = ENTRY_BITS'(in_entry_in);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [ENTRY_BITS-1:0] nbr;
    if (i == MAX_ENTRIES - 1) begin : g_top
      assign nbr = cell_q[i];
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    bsr_cell #(
      .IDX_W      (IDX_W),
      .CELL_IDX   (i),
      .ENTRY_BITS (ENTRY_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .wr_ptr  (wr_ptr),
      .rm_ptr  (rm_ptr),
      .rd_ptr  (rd_ptr),
      .din     (din),
      .nbr     (nbr),
      .q       (cell_q[i]),
      .rd_part (cell_rd[i])
    );

    for (genvar b = 0; b < ENTRY_BITS; b++) begin : g_tap
      assign rd_col[b][i] = cell_rd[i][b];
    end
  end

  // only the addressed cell drives its bits, so a wide OR per bit suffices
  for (genvar b = 0; b < ENTRY_BITS; b++) begin : g_bus
    assign rd_data[b] = |rd_col[b];
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic                    res_load;
  logic [ENTRY_PORT_W-1:0] res_entry;
  logic                    res_found;
  logic                    res_last;
  logic [VIEW_W-1:0]       res_view;

  always_comb begin
    state_nxt         = state_r;
    fill_nxt          = fill_r;
    scroll_nxt        = scroll_r;
    pop_ptr_nxt       = pop_ptr_r;
    pop_end_nxt       = pop_end_r;
    res_load          = 1'b0;
    res_entry         = '0;
    res_found         = 1'b0;
    res_last          = 1'b1;
    res_view          = '0;
    cell_ctl.load_en  = 1'b0;
    cell_ctl.shift_en = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_load = 1'b1;
          unique case (act)
            ACT_ADD: begin
              if (!full) begin
                cell_ctl.load_en = 1'b1;
                fill_nxt         = fill_r + CNT_W'(1);
                scroll_nxt       = scroll_follow;
                res_found        = 1'b1;
              end
            end
            ACT_GET: begin
              if (hit) begin
                res_entry = ENTRY_PORT_W'(rd_data);
                res_found = 1'b1;
              end
            end
            ACT_REMOVE_AT: begin
              if (hit) begin
                cell_ctl.shift_en = 1'b1;
                fill_nxt          = fill_r - CNT_W'(1);
                scroll_nxt        = scroll_follow;
                res_entry         = ENTRY_PORT_W'(rd_data);
                res_found         = 1'b1;
              end
            end
            ACT_REMOVE_TOP: begin
              // scroll follows even when nothing is popped
              fill_nxt   = CNT_W'(fill_pop);
              scroll_nxt = scroll_follow;
              if (n_pop != '0) begin
                res_entry = ENTRY_PORT_W'(rd_data);
                res_found = 1'b1;
                res_last  = n_pop == CW'(1);
                if (n_pop != CW'(1)) begin
                  state_nxt   = ST_POP;
                  pop_ptr_nxt = CNT_W'(fill_pop) + CNT_W'(1);
                  pop_end_nxt = fill_r;
                end
              end
            end
            ACT_CLEAR: begin
              fill_nxt   = '0;
              scroll_nxt = '0;
            end
            ACT_POSITION: begin
              res_found = 1'b1;
              res_view  = pos_view;
            end
            default: ;  // unknown action: no change, empty result
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          res_load    = 1'b1;
          res_entry   = ENTRY_PORT_W'(rd_data);
          res_found   = 1'b1;
          res_last    = pop_last;
          pop_ptr_nxt = pop_ptr_inc;
          if (pop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      scroll_r    <= '0;
      pop_ptr_r   <= '0;
      pop_end_r   <= '0;
      vis_r       <= VIS_W'(1);
      follow_r    <= 1'b0;
      spread_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      scroll_r    <= scroll_nxt;
      pop_ptr_r   <= pop_ptr_nxt;
      pop_end_r   <= pop_end_nxt;
      vis_r       <= vis_nxt;
      follow_r    <= follow_nxt;
      spread_r    <= spread_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, reported with fill and scroll after the request
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_entry_r  <= res_entry;
      out_found_r  <= res_found;
      out_last_r   <= res_last;
      out_view_r   <= res_view;
      out_fill_r   <= LEVEL_W'(fill_nxt);
      out_scroll_r <= LEVEL_W'(scroll_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_entry_out  = out_entry_r;
  assign out_found      = out_found_r;
  assign out_last       = out_last_r;
  assign out_view_slot  = out_view_r;
  assign out_fill_level = out_fill_r;
  assign out_scroll_now = out_scroll_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_ENTRIES))
    else $error("fill count above capacity");

  a_pop_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> (pop_ptr_r < pop_end_r) && (pop_end_r > fill_r))
    else $error("pop pointer outside popped range");

  a_pop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> !in_ready)
    else $error("request taken during multi-pop");

  a_pop_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP && out_free && pop_last) |=> (state_r == ST_IDLE) && out_last)
    else $error("multi-pop did not end on its last result");

  a_shift_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctl.shift_en |=> (fill_r == $past(fill_r) - CNT_W'(1)))
    else $error("compaction without matching fill decrement");

endmodule

`default_nettype wire

// ===== tb/stack_checker.sv =====
// Checker for the bounded stack: tracks register writes, predicts results, compares them.
module stack_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [bsr_pkg::PADDR_W-1:0]      paddr,
  input  logic [bsr_pkg::PDATA_W-1:0]      pwdata,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [bsr_pkg::ACTION_W-1:0]     in_action,
  input  logic [bsr_pkg::ENTRY_PORT_W-1:0] in_entry_in,
  input  logic [bsr_pkg::SLOT_W-1:0]       in_slot_index,
  input  logic [bsr_pkg::TAKE_W-1:0]       in_take_count,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [bsr_pkg::ENTRY_PORT_W-1:0] out_entry_out,
  input  logic                             out_found,
  input  logic                             out_last,
  input  logic [bsr_pkg::VIEW_W-1:0]       out_view_slot,
  input  logic [bsr_pkg::LEVEL_W-1:0]      out_fill_level,
  input  logic [bsr_pkg::LEVEL_W-1:0]      out_scroll_now,
  output int                               results_due,
  output int                               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bsr_pkg::*;

  typedef struct packed {
    logic [ENTRY_PORT_W-1:0] entry;
    logic                    found;
    logic                    last;
    logic [VIEW_W-1:0]       view;
    logic [LEVEL_W-1:0]      fill;
    logic [LEVEL_W-1:0]      scroll;
  } stack_result_t;

  logic [ENTRY_PORT_W-1:0] stack_cells [MAX_ENTRIES_DEF];
  int unsigned             stack_depth;
  int unsigned             scroll_pos;
  logic [VIS_W-1:0]        window_reg;
  logic                    follow_reg;
  logic                    spread_reg;
  stack_result_t           results_owed [$];

  // out-of-range window sizes clamp to 1..WINDOW_MAX
  function automatic int unsigned window_span();
    if (window_reg == 0) return 1;
    if (window_reg > WINDOW_MAX) return WINDOW_MAX;
    return window_reg;
  endfunction

  function automatic void track_top();
    if (follow_reg)
      scroll_pos = (stack_depth > window_span()) ? stack_depth - window_span() : 0;
  endfunction

  function automatic void owe_result(logic [ENTRY_PORT_W-1:0] entry, logic found,
                                     logic last, logic [VIEW_W-1:0] view);
    stack_result_t r;
    r.entry  = entry;
    r.found  = found;
    r.last   = last;
    r.view   = view;
    r.fill   = LEVEL_W'(stack_depth);
    r.scroll = LEVEL_W'(scroll_pos);
    results_owed.push_back(r);
  endfunction

  function automatic void step_stack(logic [ACTION_W-1:0] act, logic [ENTRY_PORT_W-1:0] entry,
                                     logic [SLOT_W-1:0] idx, logic [TAKE_W-1:0] take);
    int unsigned             n;
    int unsigned             span;
    logic [ENTRY_PORT_W-1:0] taken;
    logic [VIEW_W-1:0]       view;
    case (act)
      ACT_ADD: begin
        if (stack_depth < MAX_ENTRIES_DEF) begin
          stack_cells[stack_depth] = entry;
          stack_depth++;
          track_top();
          owe_result('0, 1'b1, 1'b1, '0);
        end else begin
          owe_result('0, 1'b0, 1'b1, '0);
        end
      end
      ACT_GET: begin
        if (idx < stack_depth) owe_result(stack_cells[stack_depth - idx - 1], 1'b1, 1'b1, '0);
        else owe_result('0, 1'b0, 1'b1, '0);
      end
      ACT_REMOVE_AT: begin
        if (idx < stack_depth) begin
          taken = stack_cells[idx];
          stack_depth--;
          for (int k = idx; k < stack_depth; k++) stack_cells[k] = stack_cells[k+1];
          track_top();
          owe_result(taken, 1'b1, 1'b1, '0);
        end else begin
          owe_result('0, 1'b0, 1'b1, '0);
        end
      end
      ACT_REMOVE_TOP: begin
        n = (take < stack_depth) ? take : stack_depth;
        if (n > RESULT_CAP) n = RESULT_CAP;
        stack_depth -= n;
        track_top();
        if (n == 0) owe_result('0, 1'b0, 1'b1, '0);
        // lowest popped entry leaves first
        for (int k = 0; k < n; k++)
          owe_result(stack_cells[stack_depth + k], 1'b1, (k + 1 == n), '0);
      end
      ACT_CLEAR: begin
        stack_depth = 0;
        scroll_pos  = 0;
        owe_result('0, 1'b0, 1'b1, '0);
      end
      ACT_POSITION: begin
        span = window_span();
        if (idx < scroll_pos) view = '0;
        else if (idx >= scroll_pos + span) view = spread_reg ? VIEW_W'(span - 1) : '0;
        else view = VIEW_W'(idx - scroll_pos);
        owe_result('0, 1'b1, 1'b1, view);
      end
      default: owe_result('0, 1'b0, 1'b1, '0);
    endcase
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      stack_depth = 0;
      scroll_pos  = 0;
      window_reg  = VIS_W'(1);
      follow_reg  = 1'b0;
      spread_reg  = 1'b1;
      fail_count  = 0;
      results_owed.delete();
      foreach (stack_cells[k]) stack_cells[k] = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_VISIBLE: window_reg = pwdata[VIS_W-1:0];
          REG_FOLLOW:  follow_reg = pwdata[0];
          REG_SPREAD:  spread_reg = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (results_owed.size() == 0) begin
          $error("unexpected result: entry_out %0d found %0d", out_entry_out, out_found);
          fail_count++;
        end else begin
          want = results_owed.pop_front();
          compare_field("entry_out", want.entry, out_entry_out);
          compare_field("found", want.found, out_found);
          compare_field("last", want.last, out_last);
          compare_field("view_slot", want.view, out_view_slot);
          compare_field("fill_level", want.fill, out_fill_level);
          compare_field("scroll_now", want.scroll, out_scroll_now);
        end
      end
      if (in_valid && in_ready)
        step_stack(in_action, in_entry_in, in_slot_index, in_take_count);
    end
    results_due = results_owed.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the bounded stack testbench: clock, reset, stimulus and the verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bsr_pkg::*;

  // spare action codes the block must answer with an empty result
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;
  // worst case is far below this: ~160 requests, 64 pops each, long result stalls
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_REQUESTS = 17;

  logic                    clk;
  logic                    rst_n;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_ready;
  logic [ACTION_W-1:0]     in_action;
  logic [ENTRY_PORT_W-1:0] in_entry_in;
  logic [SLOT_W-1:0]       in_slot_index;
  logic [TAKE_W-1:0]       in_take_count;
  logic                    out_valid;
  logic                    out_ready;
  logic [ENTRY_PORT_W-1:0] out_entry_out;
  logic                    out_found;
  logic                    out_last;
  logic [VIEW_W-1:0]       out_view_slot;
  logic [LEVEL_W-1:0]      out_fill_level;
  logic [LEVEL_W-1:0]      out_scroll_now;
  int                      results_due;
  int                      fail_count;
  int                      cycle_count;
  logic                    calm;  // high: neither side idles

  bounded_stack_with_indexed_removal u_top (.*);
  stack_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One request: optional idle gap with valid low, then hold valid and the
  // payload until the block takes it. Everything moves on the falling edge.
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [ENTRY_PORT_W-1:0] entry,
                              input logic [SLOT_W-1:0] idx, input logic [TAKE_W-1:0] take);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_entry_in   <= entry;
    in_slot_index <= idx;
    in_take_count <= take;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random request. Indices lean towards the low end so that get and
  // remove-at mostly hit live entries; pop counts are mostly small.
  task automatic random_request();
    int                  pick;
    logic [ACTION_W-1:0] act;
    logic [SLOT_W-1:0]   idx;
    logic [TAKE_W-1:0]   take;
    pick = $urandom_range(0, 99);
    if (pick < 35) act = ACT_ADD;
    else if (pick < 50) act = ACT_GET;
    else if (pick < 63) act = ACT_REMOVE_AT;
    else if (pick < 73) act = ACT_REMOVE_TOP;
    else if (pick < 76) act = ACT_CLEAR;
    else if (pick < 96) act = ACT_POSITION;
    else act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    idx  = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 63))
                                       : SLOT_W'($urandom_range(0, 7));
    take = ($urandom_range(0, 3) == 0) ? TAKE_W'($urandom_range(0, 127))
                                       : TAKE_W'($urandom_range(0, 4));
    send_request(act, ENTRY_PORT_W'($urandom_range(0, 255)), idx, take);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // APB write: setup cycle, access cycle, register taken on the edge with pready.
  task automatic write_register(input bsr_reg_t which, input logic [VIS_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {which, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_window(input logic [VIS_W-1:0] vis, input logic follow, input logic spread);
    drain();
    write_register(REG_VISIBLE, vis);
    write_register(REG_FOLLOW, VIS_W'(follow));
    write_register(REG_SPREAD, VIS_W'(spread));
  endtask

  // Random phase; every 16 requests ends in a stretch of 4 with no idling.
  task automatic run_phase();
    for (int i = 0; i < PHASE_REQUESTS; i++) begin
      calm = (i % 16) >= 12;
      random_request();
    end
    calm = 1'b0;
  endtask

  // Result side: per result, an optional random stall with ready low, then hold
  // ready high until a result is taken.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_action     = ACT_ADD;
    in_entry_in   = '0;
    in_slot_index = '0;
    in_take_count = '0;
    calm          = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, reset window settings. Empty-store cases first.
    send_request(ACT_GET, 8'h11, 6'd0, 7'd0);         // missing entry
    send_request(ACT_REMOVE_AT, 8'h22, 6'd0, 7'd0);   // missing entry
    send_request(ACT_REMOVE_TOP, 8'h33, 6'd0, 7'd0);  // nothing to pop
    send_request(ACT_REMOVE_TOP, 8'h44, 6'd63, 7'd127);
    send_request(ACT_POSITION, 8'h00, 6'd0, 7'd0);
    send_request(ACT_POSITION, 8'hff, 6'd63, 7'd64);  // beyond the window
    send_request(ACT_SPARE_A, 8'hff, 6'd63, 7'd127);
    send_request(ACT_SPARE_B, 8'h00, 6'd0, 7'd0);
    // a few entries, field extremes
    send_request(ACT_ADD, 8'h00, 6'd63, 7'd127);
    send_request(ACT_ADD, 8'hff, 6'd0, 7'd0);
    send_request(ACT_ADD, 8'h5a, 6'd21, 7'd42);
    send_request(ACT_ADD, 8'ha5, 6'd42, 7'd85);
    send_request(ACT_GET, 8'h00, 6'd0, 7'd0);         // top
    send_request(ACT_GET, 8'h00, 6'd3, 7'd0);         // bottom
    send_request(ACT_GET, 8'h00, 6'd4, 7'd0);         // one past the fill
    send_request(ACT_GET, 8'h00, 6'd63, 7'd0);
    send_request(ACT_REMOVE_AT, 8'h00, 6'd1, 7'd0);   // gap closes
    send_request(ACT_REMOVE_AT, 8'h00, 6'd63, 7'd0);
    send_request(ACT_REMOVE_TOP, 8'h00, 6'd0, 7'd1);
    send_request(ACT_REMOVE_TOP, 8'h00, 6'd0, 7'd64); // asks more than held
    send_request(ACT_ADD, 8'h3c, 6'd0, 7'd0);
    send_request(ACT_CLEAR, 8'h00, 6'd0, 7'd0);
    send_request(ACT_GET, 8'h00, 6'd0, 7'd0);

    // Zero window acts as one; scroll follows the top.
    set_window(7'd0, 1'b1, 1'b0);
    run_phase();

    // Fill to capacity with a small tracking window, overflow at last slot:
    // the extra add is refused, positions land below the window and inside it, up
    // to its top slot, then one pop request empties the lot.
    set_window(7'd5, 1'b1, 1'b1);
    send_request(ACT_CLEAR, 8'h00, 6'd0, 7'd0);
    calm = 1'b1;
    repeat (MAX_ENTRIES_DEF + 1)
      send_request(ACT_ADD, ENTRY_PORT_W'($urandom_range(0, 255)), 6'd0, 7'd0);
    calm = 1'b0;
    send_request(ACT_POSITION, 8'h00, 6'd0, 7'd0);
    send_request(ACT_POSITION, 8'h00, 6'd61, 7'd0);
    send_request(ACT_POSITION, 8'h00, 6'd63, 7'd0);
    send_request(ACT_GET, 8'h00, 6'd63, 7'd0);
    send_request(ACT_REMOVE_TOP, 8'h00, 6'd0, 7'd64);
    run_phase();

    // Widest window, no tracking; scroll holds its last value.
    set_window(7'd64, 1'b0, 1'b0);
    run_phase();

    // Window above the limit acts as the limit.
    set_window(7'd127, 1'b1, 1'b1);
    run_phase();

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bsr_pkg.sv
design/bsr_cell.sv
design/bounded_stack_with_indexed_removal.sv
tb/stack_checker.sv
tb/testbench.sv
